>>> src/vdib_pkg.sv
// Shared types and constants for the vertex dedup index builder.
package vdib_pkg;

  localparam int DistinctDepth = 1024;
  localparam int HandleDepth   = 4096;
  localparam int SlotW    = $clog2(DistinctDepth);
  localparam int HandleW  = $clog2(HandleDepth);
  localparam int DCountW  = SlotW + 1;
  localparam int HCountW  = HandleW + 1;
  localparam int CoordW   = 32;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OOB  = 2'd1,
    ST_FULL = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_SCAN_WAIT,
    S_VTX_DONE,
    S_TRI_MAP,
    S_TRI_MAP_WAIT,
    S_TRI_RD,
    S_TRI_RD_WAIT,
    S_TRI_BOX,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] z;
  } vec_t;

endpackage

>>> src/vdib_store.sv
// Distinct vertex store and handle map memories with registered reads.
module vdib_store
  import vdib_pkg::*;
(
  input  logic               clk,
  input  logic               vwe,
  input  logic [SlotW-1:0]   vwaddr,
  input  vec_t               vwdata,
  input  logic [SlotW-1:0]   vraddr,
  output vec_t               vrdata,
  input  logic               hwe,
  input  logic [HandleW-1:0] hwaddr,
  input  logic [SlotW-1:0]   hwdata,
  input  logic [HandleW-1:0] hraddr,
  output logic [SlotW-1:0]   hrdata
);

  vec_t             vmem [DistinctDepth];
  logic [SlotW-1:0] hmem [HandleDepth];

  always_ff @(posedge clk) begin
    if (vwe) begin
      vmem[vwaddr] <= vwdata;
    end
    vrdata <= vmem[vraddr];
  end

  always_ff @(posedge clk) begin
    if (hwe) begin
      hmem[hwaddr] <= hwdata;
    end
    hrdata <= hmem[hraddr];
  end

endmodule

>>> src/vdib_box.sv
// Bounding box registers grown by signed min and max compares on each axis.
module vdib_box
  import vdib_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic upd,
  input  vec_t v,
  output vec_t least,
  output vec_t most
);

  function automatic logic [CoordW-1:0] smin(input logic [CoordW-1:0] a,
                                             input logic [CoordW-1:0] b);
    return ($signed(a) < $signed(b)) ? a : b;
  endfunction

  function automatic logic [CoordW-1:0] smax(input logic [CoordW-1:0] a,
                                             input logic [CoordW-1:0] b);
    return ($signed(a) > $signed(b)) ? a : b;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      least <= {3{1'b0, {(CoordW-1){1'b1}}}};
      most  <= {3{1'b1, {(CoordW-1){1'b0}}}};
    end else if (upd) begin
      least.x <= smin(least.x, v.x);
      least.y <= smin(least.y, v.y);
      least.z <= smin(least.z, v.z);
      most.x  <= smax(most.x, v.x);
      most.y  <= smax(most.y, v.y);
      most.z  <= smax(most.z, v.z);
    end
  end

endmodule

>>> src/vertex_dedup_index_builder.sv
// Top level of the vertex dedup index builder: sequencer, stores and box.
// An added vertex is compared against the stored distinct vertices one at a
// time through a single memory read port, in S_SCAN and S_SCAN_WAIT for each
// stored vertex. The scan stops at the first matching slot; a new vertex is
// compared against every stored one. A triangle reads the handle map and then
// the vertex store once per corner through those ports, and skips the reads
// when a corner handle is unissued. One item is in work at a time; s_tready is
// low until its result has been taken, and a low m_tready stalls it.
// The result register holds until taken.
module vertex_dedup_index_builder
  import vdib_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // tdata: coord_x, coord_y, coord_z, corner_a, corner_b, corner_c, pad
  input  logic [135:0] s_tdata,
  // tuser: operation
  input  logic         s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  // tdata: status, handle, slot_a, slot_b, slot_c, box_min_x/y/z, box_max_x/y/z
  output logic [239:0] m_tdata
);

  state_t state, state_next;

  vec_t               coord;
  logic [HandleW-1:0] corner [3];
  logic [DCountW-1:0] dcount;
  logic [HCountW-1:0] hcount;
  logic [DCountW-1:0] idx;
  logic [1:0]         ci;
  logic [SlotW-1:0]   slot [3];
  logic [1:0]         status;
  logic [HandleW-1:0] handle;
  logic [SlotW-1:0]   found;
  logic               hit;

  vec_t               vrdata;
  logic [SlotW-1:0]   hrdata;
  logic               vwe, hwe, box_upd;
  logic [SlotW-1:0]   vraddr;
  vec_t               least, most;

  logic oob;
  assign oob = ({1'b0, corner[0]} >= hcount) || ({1'b0, corner[1]} >= hcount) ||
               ({1'b0, corner[2]} >= hcount);

  vdib_store u_store (
    .clk, .vwe, .vwaddr(dcount[SlotW-1:0]), .vwdata(coord), .vraddr, .vrdata,
    .hwe, .hwaddr(hcount[HandleW-1:0]),
    .hwdata(hit ? found : dcount[SlotW-1:0]),
    .hraddr(corner[ci]), .hrdata
  );

  vdib_box u_box (.clk, .rst, .upd(box_upd), .v(vrdata), .least, .most);

  // Keep the corner address through the wait so the box sees that corner.
  assign vraddr = (state == S_TRI_RD || state == S_TRI_RD_WAIT) ? slot[ci] :
                  idx[SlotW-1:0];

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:         if (s_tvalid) state_next = s_tuser ? S_TRI_MAP : S_SCAN;
      S_SCAN:         state_next = (idx < dcount) ? S_SCAN_WAIT : S_VTX_DONE;
      S_SCAN_WAIT:    state_next = (vrdata == coord) ? S_VTX_DONE : S_SCAN;
      S_VTX_DONE:     state_next = S_OUT;
      S_TRI_MAP:      state_next = oob ? S_OUT : S_TRI_MAP_WAIT;
      S_TRI_MAP_WAIT: state_next = (ci == 2'd2) ? S_TRI_RD : S_TRI_MAP;
      S_TRI_RD:       state_next = S_TRI_RD_WAIT;
      S_TRI_RD_WAIT:  state_next = S_TRI_BOX;
      S_TRI_BOX:      state_next = (ci == 2'd2) ? S_OUT : S_TRI_RD;
      S_OUT:          if (m_tready) state_next = S_IDLE;
      default:        state_next = S_IDLE;
    endcase
  end

  always_comb begin
    s_tready = (state == S_IDLE);
    m_tvalid = (state == S_OUT);
    box_upd  = (state == S_TRI_BOX);
    vwe = 1'b0;
    hwe = 1'b0;
    if (state == S_VTX_DONE && hcount < HCountW'(HandleDepth) &&
        (hit || dcount < DCountW'(DistinctDepth))) begin
      hwe = 1'b1;
      vwe = !hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      dcount <= '0;
      hcount <= '0;
    end else begin
      state <= state_next;
      if (vwe) dcount <= dcount + 1'b1;
      if (hwe) hcount <= hcount + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        coord.x   <= s_tdata[31:0];
        coord.y   <= s_tdata[63:32];
        coord.z   <= s_tdata[95:64];
        corner[0] <= s_tdata[107:96];
        corner[1] <= s_tdata[119:108];
        corner[2] <= s_tdata[131:120];
        idx    <= '0;
        ci     <= '0;
        hit    <= 1'b0;
        status <= ST_OK;
        handle <= '0;
        slot[0] <= '0;
        slot[1] <= '0;
        slot[2] <= '0;
      end
      S_SCAN_WAIT: begin
        // Hold the matching slot; advance otherwise.
        if (vrdata == coord) begin
          hit   <= 1'b1;
          found <= idx[SlotW-1:0];
        end else begin
          idx <= idx + 1'b1;
        end
      end
      S_VTX_DONE: begin
        if (hwe) handle <= hcount[HandleW-1:0];
        else     status <= ST_FULL;
      end
      S_TRI_MAP: if (oob) status <= ST_OOB;
      S_TRI_MAP_WAIT: begin
        slot[ci] <= hrdata;
        ci <= (ci == 2'd2) ? 2'd0 : ci + 1'b1;
      end
      S_TRI_BOX: ci <= ci + 1'b1;
      default: ;
    endcase
  end

  assign m_tdata = {4'd0, most.z, most.y, most.x, least.z, least.y, least.x,
                    slot[2], slot[1], slot[0], handle, status};

endmodule

>>> bench/vertex_dedup_index_builder_test.sv
// Self-checking bench for the vertex dedup index builder: directed, random and stall tests.
module vertex_dedup_index_builder_test
  import vdib_pkg::*;
();

  localparam int WatchLimit = 20000;
  localparam int HoldCycles = 400;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  // tdata: coord_x, coord_y, coord_z, corner_a, corner_b, corner_c, pad
  logic [135:0] s_tdata;
  // tuser: operation
  logic         s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  // tdata: status, handle, slot_a, slot_b, slot_c, box_min_x/y/z, box_max_x/y/z
  logic [239:0] m_tdata;

  typedef struct packed {
    status_t            status;
    logic [HandleW-1:0] handle;
    logic [SlotW-1:0]   slot_a;
    logic [SlotW-1:0]   slot_b;
    logic [SlotW-1:0]   slot_c;
    logic [CoordW-1:0]  lo_x, lo_y, lo_z;
    logic [CoordW-1:0]  hi_x, hi_y, hi_z;
  } mesh_result_t;

  // Shadow copy of the block's stores.
  logic [CoordW-1:0]  shadow_x [DistinctDepth];
  logic [CoordW-1:0]  shadow_y [DistinctDepth];
  logic [CoordW-1:0]  shadow_z [DistinctDepth];
  logic [SlotW-1:0]   shadow_map [HandleDepth];
  int                 distinct_seen;
  int                 handles_issued;
  logic [CoordW-1:0]  box_lo [3];
  logic [CoordW-1:0]  box_hi [3];

  mesh_result_t pending_results[$];
  logic [CoordW-1:0] pool_x[$], pool_y[$], pool_z[$];

  int  mismatches;
  int  results_checked;
  int  idle_cycles;
  int  tri_ok, tri_oob, vtx_full;
  bit  quiet;
  bit  hold_req;

  localparam logic OpVertex   = 1'b0;
  localparam logic OpTriangle = 1'b1;

  vertex_dedup_index_builder dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Compute the expected result of one accepted item and advance the shadow state.
  task automatic predict_mesh_item(input logic op, input logic [CoordW-1:0] x, y, z,
                                   input logic [HandleW-1:0] a, b, c);
    mesh_result_t r;
    int found;
    logic [SlotW-1:0] sl [3];
    logic [CoordW-1:0] v;
    r.status = ST_OK;
    r.handle = '0;
    r.slot_a = '0;
    r.slot_b = '0;
    r.slot_c = '0;
    if (op == OpVertex) begin
      found = distinct_seen;
      for (int s = 0; s < distinct_seen; s++) begin
        if (shadow_x[s] == x && shadow_y[s] == y && shadow_z[s] == z) begin
          found = s;
          break;
        end
      end
      if (handles_issued >= HandleDepth) begin
        r.status = ST_FULL;
      end else if (found == distinct_seen && distinct_seen >= DistinctDepth) begin
        r.status = ST_FULL;
      end else begin
        if (found == distinct_seen) begin
          shadow_x[found] = x;
          shadow_y[found] = y;
          shadow_z[found] = z;
          distinct_seen++;
        end
        r.handle = handles_issued[HandleW-1:0];
        shadow_map[handles_issued] = found[SlotW-1:0];
        handles_issued++;
      end
      if (r.status == ST_FULL) vtx_full++;
    end else begin
      if (a >= handles_issued || b >= handles_issued || c >= handles_issued) begin
        r.status = ST_OOB;
        tri_oob++;
      end else begin
        sl[0] = shadow_map[a];
        sl[1] = shadow_map[b];
        sl[2] = shadow_map[c];
        for (int i = 0; i < 3; i++) begin
          for (int ax = 0; ax < 3; ax++) begin
            v = (ax == 0) ? shadow_x[sl[i]] : (ax == 1) ? shadow_y[sl[i]] : shadow_z[sl[i]];
            if ($signed(v) < $signed(box_lo[ax])) box_lo[ax] = v;
            if ($signed(v) > $signed(box_hi[ax])) box_hi[ax] = v;
          end
        end
        r.slot_a = sl[0];
        r.slot_b = sl[1];
        r.slot_c = sl[2];
        tri_ok++;
      end
    end
    r.lo_x = box_lo[0];
    r.lo_y = box_lo[1];
    r.lo_z = box_lo[2];
    r.hi_x = box_hi[0];
    r.hi_y = box_hi[1];
    r.hi_z = box_hi[2];
    pending_results = {pending_results, r};
  endtask

  // Offer one item; return at the falling edge after its transaction.
  task automatic send_item(input logic op, input logic [CoordW-1:0] x, y, z,
                           input logic [HandleW-1:0] a, b, c);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    s_tdata  <= {4'b0, c, b, a, z, y, x};
    s_tuser  <= op;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    predict_mesh_item(op, x, y, z, a, b, c);
    @(negedge clk);
  endtask

  task automatic send_vertex(input logic [CoordW-1:0] x, y, z);
    send_item(OpVertex, x, y, z, HandleW'($urandom), HandleW'($urandom), HandleW'($urandom));
  endtask

  task automatic send_triangle(input logic [HandleW-1:0] a, b, c);
    send_item(OpTriangle, $urandom, $urandom, $urandom, a, b, c);
  endtask

  function automatic logic [HandleW-1:0] issued_handle();
    return HandleW'($urandom_range(0, handles_issued - 1));
  endfunction

  task automatic test_directed();
    send_triangle(0, 0, 0);
    send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    send_vertex(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    send_vertex(32'hFFFF_FFFF, 32'h0001_0000, 32'hFFFF_0000);
    send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFE);
    send_triangle(2, 2, 2);
    send_triangle(0, 1, 3);
    send_triangle(0, 4, 5);
    send_triangle(6, 0, 0);
    send_triangle(0, 6, 0);
    send_triangle(0, 0, 6);
    send_triangle(12'hFFF, 0, 1);
    send_vertex(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    send_vertex(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    send_triangle(6, 7, 1);
    send_triangle(5, 5, 4);
  endtask

  task automatic test_random(input int count);
    int pick;
    for (int n = 0; n < 24; n++) begin
      pool_x = {pool_x, $urandom};
      pool_y = {pool_y, $urandom};
      pool_z = {pool_z, $urandom};
    end
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 1) == 0) begin
        if ($urandom_range(0, 9) == 0) begin
          send_vertex($urandom, $urandom, $urandom);
        end else begin
          pick = $urandom_range(0, pool_x.size() - 1);
          send_vertex(pool_x[pick], pool_y[pick], pool_z[pick]);
        end
      end else if ($urandom_range(0, 4) == 0) begin
        // First and last corners anywhere in the field; mostly unissued.
        send_triangle(HandleW'($urandom), issued_handle(), HandleW'($urandom));
      end else begin
        send_triangle(issued_handle(), issued_handle(), issued_handle());
      end
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int n = 0; n < 8; n++) send_triangle(issued_handle(), issued_handle(), issued_handle());
    wait (!hold_req);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    wait (!rst);
    forever begin
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(negedge clk);
      end else begin
        m_tready <= 1'b1;
        @(negedge clk);
      end
    end
  end

  // Compare each result transaction with the oldest expectation.
  always @(posedge clk) begin
    mesh_result_t want;
    mesh_result_t got;
    if (!rst && m_tvalid && m_tready) begin
      got.status = status_t'(m_tdata[1:0]);
      got.handle = m_tdata[13:2];
      got.slot_a = m_tdata[23:14];
      got.slot_b = m_tdata[33:24];
      got.slot_c = m_tdata[43:34];
      got.lo_x   = m_tdata[75:44];
      got.lo_y   = m_tdata[107:76];
      got.lo_z   = m_tdata[139:108];
      got.hi_x   = m_tdata[171:140];
      got.hi_y   = m_tdata[203:172];
      got.hi_z   = m_tdata[235:204];
      results_checked++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %h", m_tdata);
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"result %0d mismatch: exp st=%0d h=%0d sl=%0d/%0d/%0d ",
                      "lo=%h/%h/%h hi=%h/%h/%h, got st=%0d h=%0d sl=%0d/%0d/%0d ",
                      "lo=%h/%h/%h hi=%h/%h/%h"}, results_checked,
                     want.status, want.handle, want.slot_a, want.slot_b, want.slot_c,
                     want.lo_x, want.lo_y, want.lo_z, want.hi_x, want.hi_y, want.hi_z,
                     got.status, got.handle, got.slot_a, got.slot_b, got.slot_c,
                     got.lo_x, got.lo_y, got.lo_z, got.hi_x, got.hi_y, got.hi_z);
        end
      end
    end
  end

  // Watchdog: end the run if no transaction happens for too long.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tuser = 1'b0;
    s_tdata = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    mismatches = 0;
    results_checked = 0;
    idle_cycles = 0;
    tri_ok = 0;
    tri_oob = 0;
    vtx_full = 0;
    distinct_seen = 0;
    handles_issued = 0;
    for (int ax = 0; ax < 3; ax++) begin
      box_lo[ax] = 32'h7FFF_FFFF;
      box_hi[ax] = 32'h8000_0000;
    end
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_directed();
    test_random(400);
    test_backpressure();
    quiet = 1'b1;
    test_random(25);
    s_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d results: %0d triangles placed, %0d with unissued corners,",
             results_checked, tri_ok, tri_oob);
    $display("%0d vertices refused with full stores; %0d distinct, %0d handles at the end",
             vtx_full, distinct_seen, handles_issued);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("mismatches: %0d, results still expected: %0d", mismatches,
               pending_results.size());
      $display("tb: failure");
    end
    $finish;
  end

endmodule

>>> sim.f
src/vdib_pkg.sv
src/vdib_store.sv
src/vdib_box.sv
src/vertex_dedup_index_builder.sv
bench/vertex_dedup_index_builder_test.sv
